// ===== rtl/ezr_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table for the ZYX Euler
// to rotation matrix block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ezr_pkg;

	// Field width of every angle and matrix entry on the ports.
	localparam int FIELD_W = 16;

	// Default parameter values for the top level.
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 14;

	// Rotation-mode CORDIC: 30 stages on a 32-bit binary angle, x and y scaled by 2^30.
	localparam int CORDIC_STAGES = 30;
	localparam int SCALE_BITS    = 30;
	localparam int CORDIC_W      = 32;
	localparam logic signed [CORDIC_W-1:0] GAIN_INV = 32'sd652032875;

	// Pipeline depths: angle fold, CORDIC stages and result rounding, then the
	// five stages of the matrix products.
	localparam int CORDIC_LAT = CORDIC_STAGES + 2;
	localparam int MATRIX_LAT = 5;
	localparam int TOTAL_LAT  = CORDIC_LAT + MATRIX_LAT;

	typedef logic signed [FIELD_W-1:0] field_t;

	// atan(2^-i) as a binary angle where 2^31 is 180 degrees.
	function automatic logic signed [CORDIC_W-1:0] atan_step(input int i);
		logic signed [CORDIC_W-1:0] r;
		case (i)
			0:       r = 32'sd536870912;
			1:       r = 32'sd316933406;
			2:       r = 32'sd167458907;
			3:       r = 32'sd85004756;
			4:       r = 32'sd42667331;
			5:       r = 32'sd21354465;
			6:       r = 32'sd10679838;
			7:       r = 32'sd5340245;
			8:       r = 32'sd2670163;
			9:       r = 32'sd1335087;
			10:      r = 32'sd667544;
			11:      r = 32'sd333772;
			12:      r = 32'sd166886;
			13:      r = 32'sd83443;
			14:      r = 32'sd41722;
			15:      r = 32'sd20861;
			16:      r = 32'sd10430;
			17:      r = 32'sd5215;
			18:      r = 32'sd2608;
			19:      r = 32'sd1304;
			20:      r = 32'sd652;
			21:      r = 32'sd326;
			22:      r = 32'sd163;
			23:      r = 32'sd81;
			24:      r = 32'sd41;
			25:      r = 32'sd20;
			26:      r = 32'sd10;
			27:      r = 32'sd5;
			28:      r = 32'sd3;
			29:      r = 32'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ezr_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of one binary angle.
// Depends on ezr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ezr_cordic #(
	parameter int ANGLE_WIDTH = ezr_pkg::ANGLE_WIDTH_DEF,
	parameter int FRAC_BITS   = ezr_pkg::FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          en,
	input  ezr_pkg::field_t              angle,
	output logic signed [FRAC_BITS+1:0] sin_val,
	output logic signed [FRAC_BITS+1:0] cos_val
);
	import ezr_pkg::*;

	localparam int QW = FRAC_BITS + 2;
	localparam int RS = SCALE_BITS - FRAC_BITS;
	localparam int N  = CORDIC_STAGES;
	localparam int RW = CORDIC_W + 1;

	logic [CORDIC_W-1:0] a_raw;
	logic [CORDIC_W-1:0] a_fold;
	logic                fold;

	// Stage i holds x, y and z after i micro-rotations.
	logic signed [CORDIC_W-1:0] x_s [0:N];
	logic signed [CORDIC_W-1:0] y_s [0:N];
	logic signed [CORDIC_W-1:0] z_s [0:N];
	logic [N:0]                 fold_s;

	logic signed [RW-1:0] x_rnd;
	logic signed [RW-1:0] y_rnd;

	// Only the low ANGLE_WIDTH bits count; they go to the top of a 32-bit angle.
	assign a_raw = {{(CORDIC_W-FIELD_W){1'b0}}, angle} << (CORDIC_W - ANGLE_WIDTH);

	// Angles in the second and third quadrants are turned by 180 degrees.
	assign fold   = a_raw[CORDIC_W-1] ^ a_raw[CORDIC_W-2];
	assign a_fold = {a_raw[CORDIC_W-1] ^ fold, a_raw[CORDIC_W-2:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= GAIN_INV;
			y_s[0]    <= '0;
			z_s[0]    <= signed'(a_fold);
			fold_s[0] <= fold;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic signed [CORDIC_W-1:0] AT = atan_step(i);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AT;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AT;
				end
				fold_s[i+1] <= fold_s[i];
			end
		end
	end

	if (RS > 0) begin : g_round
		localparam logic signed [RW-1:0] HALF = RW'(1) <<< (RS - 1);
		assign x_rnd = ($signed({x_s[N][CORDIC_W-1], x_s[N]}) + HALF) >>> RS;
		assign y_rnd = ($signed({y_s[N][CORDIC_W-1], y_s[N]}) + HALF) >>> RS;
	end else begin : g_noround
		assign x_rnd = {x_s[N][CORDIC_W-1], x_s[N]};
		assign y_rnd = {y_s[N][CORDIC_W-1], y_s[N]};
	end

	function automatic logic signed [QW-1:0] clamp_q(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] one;
		logic signed [RW-1:0] c;
		one = RW'(1) <<< FRAC_BITS;
		if (v > one) begin
			c = one;
		end else if (v < -one) begin
			c = -one;
		end else begin
			c = v;
		end
		return c[QW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= fold_s[N] ? -clamp_q(y_rnd) : clamp_q(y_rnd);
			cos_val <= fold_s[N] ? -clamp_q(x_rnd) : clamp_q(x_rnd);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ezr_matrix.sv =====
// Five-stage product and sum pipeline that forms the nine rotation matrix
// entries from three sine/cosine pairs. Depends on ezr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ezr_matrix #(
	parameter int FRAC_BITS = ezr_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         en,
	input  wire signed [FRAC_BITS+1:0] sz,
	input  wire signed [FRAC_BITS+1:0] cz,
	input  wire signed [FRAC_BITS+1:0] sy,
	input  wire signed [FRAC_BITS+1:0] cy,
	input  wire signed [FRAC_BITS+1:0] sx,
	input  wire signed [FRAC_BITS+1:0] cx,
	output ezr_pkg::field_t             rot_00,
	output ezr_pkg::field_t             rot_01,
	output ezr_pkg::field_t             rot_02,
	output ezr_pkg::field_t             rot_10,
	output ezr_pkg::field_t             rot_11,
	output ezr_pkg::field_t             rot_12,
	output ezr_pkg::field_t             rot_20,
	output ezr_pkg::field_t             rot_21,
	output ezr_pkg::field_t             rot_22
);
	import ezr_pkg::*;

	localparam int QW = FRAC_BITS + 2;
	localparam int PW = 2 * QW;
	localparam int SW = QW + 1;

	// First-level products.
	localparam int P_CYCZ = 0;
	localparam int P_CYSZ = 1;
	localparam int P_CXSZ = 2;
	localparam int P_CXCZ = 3;
	localparam int P_SXCY = 4;
	localparam int P_SXSZ = 5;
	localparam int P_SXCZ = 6;
	localparam int P_CXCY = 7;
	localparam int P_SXSY = 8;
	localparam int P_CXSY = 9;
	localparam int NP1    = 10;

	// Second-level products.
	localparam int Q_SXSY_CZ = 0;
	localparam int Q_SXSY_SZ = 1;
	localparam int Q_CXSY_CZ = 2;
	localparam int Q_CXSY_SZ = 3;
	localparam int NP2       = 4;

	logic signed [PW-1:0] p_s1 [0:NP1-1];
	logic signed [QW-1:0] sz_s1, cz_s1, sy_s1;

	logic signed [QW-1:0] r_s2 [0:NP1-1];
	logic signed [QW-1:0] sz_s2, cz_s2, sy_s2;

	logic signed [PW-1:0] q_s3 [0:NP2-1];
	logic signed [QW-1:0] r_s3 [0:NP1-1];
	logic signed [QW-1:0] sy_s3;

	logic signed [QW-1:0] t_s4 [0:NP2-1];
	logic signed [QW-1:0] r_s4 [0:NP1-1];
	logic signed [QW-1:0] sy_s4;

	// Round half up to FRAC_BITS fraction bits.
	function automatic logic signed [QW-1:0] round_q(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] half;
		logic signed [PW-1:0] t;
		half = PW'(1) <<< (FRAC_BITS - 1);
		t    = (p + half) >>> FRAC_BITS;
		return t[QW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] ext_q(input logic signed [QW-1:0] v);
		return {v[QW-1], v};
	endfunction

	// Saturate to plus or minus one and keep the low field bits.
	function automatic field_t pack_q(input logic signed [SW-1:0] v);
		logic signed [SW-1:0]         one;
		logic signed [SW-1:0]         c;
		logic signed [SW+FIELD_W-1:0] w;
		one = SW'(1) <<< FRAC_BITS;
		if (v > one) begin
			c = one;
		end else if (v < -one) begin
			c = -one;
		end else begin
			c = v;
		end
		w = {{FIELD_W{c[SW-1]}}, c};
		return w[FIELD_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[P_CYCZ] <= cy * cz;
			p_s1[P_CYSZ] <= cy * sz;
			p_s1[P_CXSZ] <= cx * sz;
			p_s1[P_CXCZ] <= cx * cz;
			p_s1[P_SXCY] <= sx * cy;
			p_s1[P_SXSZ] <= sx * sz;
			p_s1[P_SXCZ] <= sx * cz;
			p_s1[P_CXCY] <= cx * cy;
			p_s1[P_SXSY] <= sx * sy;
			p_s1[P_CXSY] <= cx * sy;
			sz_s1        <= sz;
			cz_s1        <= cz;
			sy_s1        <= sy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NP1; k++) begin
				r_s2[k] <= round_q(p_s1[k]);
			end
			sz_s2 <= sz_s1;
			cz_s2 <= cz_s1;
			sy_s2 <= sy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3[Q_SXSY_CZ] <= r_s2[P_SXSY] * cz_s2;
			q_s3[Q_SXSY_SZ] <= r_s2[P_SXSY] * sz_s2;
			q_s3[Q_CXSY_CZ] <= r_s2[P_CXSY] * cz_s2;
			q_s3[Q_CXSY_SZ] <= r_s2[P_CXSY] * sz_s2;
			r_s3            <= r_s2;
			sy_s3           <= sy_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NP2; k++) begin
				t_s4[k] <= round_q(q_s3[k]);
			end
			r_s4  <= r_s3;
			sy_s4 <= sy_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_00 <= pack_q(ext_q(r_s4[P_CYCZ]));
			rot_01 <= pack_q(ext_q(r_s4[P_CYSZ]));
			rot_02 <= pack_q(-ext_q(sy_s4));
			rot_10 <= pack_q(ext_q(t_s4[Q_SXSY_CZ]) - ext_q(r_s4[P_CXSZ]));
			rot_11 <= pack_q(ext_q(r_s4[P_CXCZ]) + ext_q(t_s4[Q_SXSY_SZ]));
			rot_12 <= pack_q(ext_q(r_s4[P_SXCY]));
			rot_20 <= pack_q(ext_q(r_s4[P_SXSZ]) + ext_q(t_s4[Q_CXSY_CZ]));
			rot_21 <= pack_q(ext_q(t_s4[Q_CXSY_SZ]) - ext_q(r_s4[P_SXCZ]));
			rot_22 <= pack_q(ext_q(r_s4[P_CXCY]));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/euler_zyx_to_rotation_matrix.sv =====
// Top level: ZYX Euler angles to rotation matrix, fully pipelined.
// Depends on ezr_pkg, ezr_cordic and ezr_matrix.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake                    Payload
//  sample    in         sample_valid / sample_stall  azimuth, elevation, roll
//  matrix    out        matrix_valid / matrix_stall  rot_00 .. rot_22
//
// One request enters per clock while sample_stall is low; a fold stage folds
// the angle, 30 CORDIC stages and one rounding stage give sine and cosine, and
// five stages form the products and sums. The depth does not change with the
// parameters. Reset clears only the valid bits that travel with each request.
// A stalled result freezes the whole pipeline, so nothing is dropped or
// repeated; sample_stall is high exactly while a result waits on matrix_stall.

module euler_zyx_to_rotation_matrix #(
	parameter int ANGLE_WIDTH = ezr_pkg::ANGLE_WIDTH_DEF,
	parameter int FRAC_BITS   = ezr_pkg::FRAC_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              sample_valid,
	output logic             sample_stall,
	input  ezr_pkg::field_t  azimuth,
	input  ezr_pkg::field_t  elevation,
	input  ezr_pkg::field_t  roll,
	output logic             matrix_valid,
	input  wire              matrix_stall,
	output ezr_pkg::field_t  rot_00,
	output ezr_pkg::field_t  rot_01,
	output ezr_pkg::field_t  rot_02,
	output ezr_pkg::field_t  rot_10,
	output ezr_pkg::field_t  rot_11,
	output ezr_pkg::field_t  rot_12,
	output ezr_pkg::field_t  rot_20,
	output ezr_pkg::field_t  rot_21,
	output ezr_pkg::field_t  rot_22
);
	import ezr_pkg::*;

	localparam int QW = FRAC_BITS + 2;

	// Whole-pipeline advance: every stage moves unless the finished result
	// at the output is held by the receiver.
	logic en;

	// One valid bit per pipeline stage; the last one is the output valid.
	logic [TOTAL_LAT-1:0] vld_s;

	logic signed [QW-1:0] sin_z, cos_z;
	logic signed [QW-1:0] sin_y, cos_y;
	logic signed [QW-1:0] sin_x, cos_x;

	assign en           = !(vld_s[TOTAL_LAT-1] && matrix_stall);
	assign sample_stall = !en;
	assign matrix_valid = vld_s[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOTAL_LAT-2:0], sample_valid};
		end
	end

	// Three identical sine/cosine pipelines, one per axis.
	ezr_cordic #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_cordic_z (
		.clk     (clk),
		.en      (en),
		.angle   (azimuth),
		.sin_val (sin_z),
		.cos_val (cos_z)
	);

	ezr_cordic #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_cordic_y (
		.clk     (clk),
		.en      (en),
		.angle   (elevation),
		.sin_val (sin_y),
		.cos_val (cos_y)
	);

	ezr_cordic #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_cordic_x (
		.clk     (clk),
		.en      (en),
		.angle   (roll),
		.sin_val (sin_x),
		.cos_val (cos_x)
	);

	// Products, sums and saturation; its last stage is the output register.
	ezr_matrix #(
		.FRAC_BITS (FRAC_BITS)
	) u_matrix (
		.clk    (clk),
		.en     (en),
		.sz     (sin_z),
		.cz     (cos_z),
		.sy     (sin_y),
		.cy     (cos_y),
		.sx     (sin_x),
		.cx     (cos_x),
		.rot_00 (rot_00),
		.rot_01 (rot_01),
		.rot_02 (rot_02),
		.rot_10 (rot_10),
		.rot_11 (rot_11),
		.rot_12 (rot_12),
		.rot_20 (rot_20),
		.rot_21 (rot_21),
		.rot_22 (rot_22)
	);

endmodule

`default_nettype wire

// ===== test/rotation_matrix_checker.sv =====
// Scoreboard for the ZYX Euler to rotation matrix block: predicts each matrix
// from its request and compares it with what leaves the block. Uses ezr_pkg.
`timescale 1ns / 1ps

module rotation_matrix_checker (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              sample_valid,
	input  wire              sample_stall,
	input  ezr_pkg::field_t  azimuth,
	input  ezr_pkg::field_t  elevation,
	input  ezr_pkg::field_t  roll,
	input  wire              matrix_valid,
	input  wire              matrix_stall,
	input  ezr_pkg::field_t  rot_00,
	input  ezr_pkg::field_t  rot_01,
	input  ezr_pkg::field_t  rot_02,
	input  ezr_pkg::field_t  rot_10,
	input  ezr_pkg::field_t  rot_11,
	input  ezr_pkg::field_t  rot_12,
	input  ezr_pkg::field_t  rot_20,
	input  ezr_pkg::field_t  rot_21,
	input  ezr_pkg::field_t  rot_22,
	output int               failures,
	output int               outstanding
);

	localparam int FRAC      = ezr_pkg::FRAC_BITS_DEF;
	localparam int STEPS     = 30;
	localparam int SCALE     = 30;
	localparam int REPORT_MAX = 10;
	localparam longint KGAIN = 64'sd652032875;

	typedef logic [8:0][ezr_pkg::FIELD_W-1:0] rot_t;
	typedef struct packed {
		ezr_pkg::field_t az;
		ezr_pkg::field_t el;
		ezr_pkg::field_t ro;
		rot_t            rot;
	} pose_t;

	pose_t pose_q[$];
	pose_t want;
	rot_t  observed;
	int    mismatches = 0;

	assign failures = mismatches;

	// Arctangent of 2^-i, with 2^31 standing for 180 degrees.
	function automatic longint arctan_of(input int i);
		case (i)
			0:       return 536870912;
			1:       return 316933406;
			2:       return 167458907;
			3:       return 85004756;
			4:       return 42667331;
			5:       return 21354465;
			6:       return 10679838;
			7:       return 5340245;
			8:       return 2670163;
			9:       return 1335087;
			10:      return 667544;
			11:      return 333772;
			12:      return 166886;
			13:      return 83443;
			14:      return 41722;
			15:      return 20861;
			16:      return 10430;
			17:      return 5215;
			18:      return 2608;
			19:      return 1304;
			20:      return 652;
			21:      return 326;
			22:      return 163;
			23:      return 81;
			24:      return 41;
			25:      return 20;
			26:      return 10;
			27:      return 5;
			28:      return 3;
			29:      return 1;
			default: return 0;
		endcase
	endfunction

	function automatic longint rshift_round(input longint v, input int s);
		if (s == 0) return v;
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_unit(input longint v);
		longint one;
		one = longint'(1) << FRAC;
		if (v > one) return one;
		if (v < -one) return -one;
		return v;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return rshift_round(a * b, FRAC);
	endfunction

	// Rotation-mode CORDIC over the right half plane; the left half is folded
	// over by 180 degrees and both results negated.
	function automatic void sin_cos(input ezr_pkg::field_t ang, output longint s,
			output longint c);
		logic [31:0] a;
		logic        flip;
		longint      x, y, z, dx, dy;
		a = {ang, 16'h0000};
		flip = a[31] ^ a[30];
		if (flip) a[31] = ~a[31];
		z = longint'(signed'(a));
		x = KGAIN;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan_of(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan_of(i);
			end
		end
		x = clamp_unit(rshift_round(x, SCALE - FRAC));
		y = clamp_unit(rshift_round(y, SCALE - FRAC));
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endfunction

	function automatic rot_t rotation_of(input ezr_pkg::field_t az, input ezr_pkg::field_t el,
			input ezr_pkg::field_t ro);
		longint sz, cz, sy, cy, sx, cx, sxsy, cxsy;
		rot_t   m;
		sin_cos(az, sz, cz);
		sin_cos(el, sy, cy);
		sin_cos(ro, sx, cx);
		sxsy = qmul(sx, sy);
		cxsy = qmul(cx, sy);
		m[0] = ezr_pkg::field_t'(clamp_unit(qmul(cy, cz)));
		m[1] = ezr_pkg::field_t'(clamp_unit(qmul(cy, sz)));
		m[2] = ezr_pkg::field_t'(clamp_unit(-sy));
		m[3] = ezr_pkg::field_t'(clamp_unit(-qmul(cx, sz) + qmul(sxsy, cz)));
		m[4] = ezr_pkg::field_t'(clamp_unit(qmul(cx, cz) + qmul(sxsy, sz)));
		m[5] = ezr_pkg::field_t'(clamp_unit(qmul(sx, cy)));
		m[6] = ezr_pkg::field_t'(clamp_unit(qmul(sx, sz) + qmul(cxsy, cz)));
		m[7] = ezr_pkg::field_t'(clamp_unit(-qmul(sx, cz) + qmul(cxsy, sz)));
		m[8] = ezr_pkg::field_t'(clamp_unit(qmul(cx, cy)));
		return m;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// Results are retired before new requests are queued, so a result
			// can never be matched against the request of the same cycle.
			if (matrix_valid && !matrix_stall) begin
				observed = {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10,
					rot_02, rot_01, rot_00};
				if (pose_q.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: matrix with no request waiting", $time);
					mismatches = mismatches + 1;
				end else begin
					want = pose_q.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (observed[i] !== want.rot[i]) begin
							if (mismatches < REPORT_MAX)
								$display("%0t: rot_%0d%0d az=%0d el=%0d roll=%0d expected %0d got %0d",
									$time, i / 3, i % 3, want.az, want.el, want.ro,
									$signed(want.rot[i]), $signed(observed[i]));
							mismatches = mismatches + 1;
						end
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				want.az = azimuth;
				want.el = elevation;
				want.ro = roll;
				want.rot = rotation_of(azimuth, elevation, roll);
				pose_q.push_back(want);
			end
			outstanding <= pose_q.size();
		end
	end

endmodule

// ===== test/euler_zyx_to_rotation_matrix_test.sv =====
// Testbench top for the ZYX Euler to rotation matrix block: drives orientation
// requests, stalls the matrix side and gives the verdict. Uses ezr_pkg and the checker.
`timescale 1ns / 1ps

module euler_zyx_to_rotation_matrix_test;

	// The watchdog trips after this many cycles with no handshake on either side.
	// A correct run never comes near it.
	localparam int IDLE_LIMIT     = 2000;
	localparam int RANDOM_SAMPLES = 1630;
	localparam int DRAIN_POINT    = 800;

	// Receiver behavior, switched at random times.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_RUNS,
		STALL_HEAVY
	} stall_mode_t;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            sample_valid = 1'b0;
	logic            sample_stall;
	ezr_pkg::field_t azimuth = '0;
	ezr_pkg::field_t elevation = '0;
	ezr_pkg::field_t roll = '0;
	logic            matrix_valid;
	logic            matrix_stall = 1'b0;
	ezr_pkg::field_t rot_00, rot_01, rot_02;
	ezr_pkg::field_t rot_10, rot_11, rot_12;
	ezr_pkg::field_t rot_20, rot_21, rot_22;
	int              failures;
	int              outstanding;
	int              idle_cycles = 0;

	stall_mode_t     stall_mode = STALL_NONE;
	int              mode_left = 0;
	int              run_left = 0;
	logic            run_stalled = 1'b0;

	euler_zyx_to_rotation_matrix uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.azimuth      (azimuth),
		.elevation    (elevation),
		.roll         (roll),
		.matrix_valid (matrix_valid),
		.matrix_stall (matrix_stall),
		.rot_00       (rot_00),
		.rot_01       (rot_01),
		.rot_02       (rot_02),
		.rot_10       (rot_10),
		.rot_11       (rot_11),
		.rot_12       (rot_12),
		.rot_20       (rot_20),
		.rot_21       (rot_21),
		.rot_22       (rot_22)
	);

	rotation_matrix_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.azimuth      (azimuth),
		.elevation    (elevation),
		.roll         (roll),
		.matrix_valid (matrix_valid),
		.matrix_stall (matrix_stall),
		.rot_00       (rot_00),
		.rot_01       (rot_01),
		.rot_02       (rot_02),
		.rot_10       (rot_10),
		.rot_11       (rot_11),
		.rot_12       (rot_12),
		.rot_20       (rot_20),
		.rot_21       (rot_21),
		.rot_22       (rot_22),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Presents one request at the falling edge and holds it until the block
	// takes it. Returns just after the accepting rising edge, so a following
	// call presents its request at the next falling edge with valid still high.
	task automatic offer_sample(input ezr_pkg::field_t az, input ezr_pkg::field_t el,
			input ezr_pkg::field_t ro);
		@(negedge clk);
		sample_valid <= 1'b1;
		azimuth <= az;
		elevation <= el;
		roll <= ro;
		do @(posedge clk); while (sample_stall);
	endtask

	// Drops valid for a number of cycles; the payload keeps its last value.
	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
	endtask

	// Waits until every request sent so far has come back as a matrix.
	task automatic drain_matrices();
		hold_off(1);
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Angles for the random part. Most are uniform over the whole field, which
	// exercises every bit. The rest sit on or next to multiples of 45 degrees,
	// among them the quadrant borders where the CORDIC fold and the output clamps
	// are most likely to slip, or near the gimbal pole at plus or minus 90 degrees when asked for.
	function automatic ezr_pkg::field_t pick_angle(input bit near_pole);
		int offset;
		offset = $urandom_range(0, 6) - 3;
		if (near_pole)
			return ezr_pkg::field_t'(($urandom_range(0, 1) ? 16384 : -16384) + offset);
		case ($urandom_range(0, 9))
			6, 7:    return ezr_pkg::field_t'(8192 * $urandom_range(0, 7) + offset);
			8: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh8000;
					1:       return 16'sh7fff;
					2:       return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default: return ezr_pkg::field_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// The matrix side stalls on its own schedule: free-running stretches,
	// light and heavy random stalls, and alternating runs of stall and flow.
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(50, 300);
		end
		mode_left = mode_left - 1;
		case (stall_mode)
			STALL_NONE:  matrix_stall <= 1'b0;
			STALL_LIGHT: matrix_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: matrix_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (run_left == 0) begin
					run_stalled = ~run_stalled;
					run_left = $urandom_range(1, 20);
				end
				run_left = run_left - 1;
				matrix_stall <= run_stalled;
			end
		endcase
	end

	// Watchdog: a hung handshake on either side ends the run as a failure.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (matrix_valid && !matrix_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL euler_zyx_to_rotation_matrix");
				$finish;
			end
		end
	end

	initial begin
		int burst_left;
		bit pole;
		burst_left = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests include zero, the field extremes, the quadrant borders
		// on each axis, and elevation on and beside the gimbal pole, which the
		// block passes through without any check.
		offer_sample(0, 0, 0);
		offer_sample(32767, 32767, 32767);
		offer_sample(-32768, -32768, -32768);
		offer_sample(16384, 0, 0);
		offer_sample(0, 16384, 0);
		offer_sample(0, 0, 16384);
		offer_sample(-16384, -16384, -16384);
		offer_sample(0, 16383, 0);
		offer_sample(0, 16385, 0);
		offer_sample(0, -16383, 0);
		offer_sample(0, -16385, 0);
		offer_sample(16384, 16384, 16384);
		offer_sample(-16384, 16384, 16384);
		offer_sample(8192, 8192, 8192);
		offer_sample(1, 1, 1);
		offer_sample(-1, -1, -1);
		offer_sample(32767, -32768, 0);
		offer_sample(-32768, 16384, 32767);
		offer_sample(5461, -10923, 21845);
		offer_sample(16'sh5555, 16'shaaaa, 16'sh5555);
		offer_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
		drain_matrices();

		// Random requests in bursts. Gaps of random length separate most
		// bursts, and some bursts run straight into the next, so gaps land on
		// every pipeline phase. Halfway through, the sender waits for the
		// pipeline to empty completely before going on.
		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 48);
				if ($urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 12));
			end
			burst_left = burst_left - 1;
			if (n == DRAIN_POINT)
				drain_matrices();
			pole = ($urandom_range(0, 9) == 0);
			offer_sample(pick_angle(1'b0), pick_angle(pole), pick_angle(1'b0));
		end
		hold_off(1);

		// Let every matrix arrive, then give any stray result time to show up.
		do @(negedge clk); while (outstanding != 0);
		repeat (ezr_pkg::TOTAL_LAT + 10) @(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("PASS euler_zyx_to_rotation_matrix");
		else
			$display("FAIL euler_zyx_to_rotation_matrix");
		$finish;
	end

endmodule
